### rtl/rel_pkg.sv
// ----------------------------------------------------------------------------
// Reaction extent limiter package
// Shared widths and the command and status bundles that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rel_pkg;

  // Field widths of the stream payloads.
  localparam int CONC_W   = 32;
  localparam int COEF_W   = 5;
  localparam int EXT_W    = 32;
  localparam int LIMIT_W  = 31;

  // Packed tdata widths, padded to whole bytes.
  localparam int IN_RAW_W  = CONC_W + COEF_W + EXT_W;
  localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = 1 + 1 + LIMIT_W + LIMIT_W + 1 + EXT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // The quotient has as many bits as a clamped concentration.
  localparam int QUO_W = LIMIT_W;
  localparam int CNT_W = $clog2(QUO_W);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the incoming species transaction
    logic div_step;  // one restoring division step
    logic update;    // fold the quotient into the running minima
    logic finish;    // load the result register and clear the minima
  } rel_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;  // the current step is the final division step
    logic is_last;   // the held species closes its reaction
    logic out_free;  // the result register can take a new result
  } rel_status_t;

endpackage

### rtl/rel_ctrl.sv
// ----------------------------------------------------------------------------
// Reaction extent limiter controller
// Sequences capture, the bit-serial division, the minimum update and the
// result load for one species at a time.
// ----------------------------------------------------------------------------
module rel_ctrl
  import rel_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  rel_status_t status,
  output rel_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // A new species is taken only when the previous one is fully folded in.
  assign s_tready = (state == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.update   = 1'b0;
    cmd.finish   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = status.is_last ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        // Hold until the result register has room.
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/rel_dpath.sv
// ----------------------------------------------------------------------------
// Reaction extent limiter datapath
// Restoring divider, running forward and reverse minima, extent clipping
// and the result register of the master side.
// ----------------------------------------------------------------------------
module rel_dpath
  import rel_pkg::*;
#(
  parameter int COEF_MAX = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  rel_cmd_t              cmd,
  output rel_status_t           status
);

  localparam int DIV_W = $clog2(COEF_MAX + 1);

  // Input field views.
  logic signed [CONC_W-1:0] in_conc;
  logic signed [COEF_W-1:0] in_coef;
  logic signed [EXT_W-1:0]  in_ext;
  logic [COEF_W-1:0]        coef_mag;
  logic [DIV_W-1:0]         div_sat;
  logic [QUO_W-1:0]         dividend;

  assign in_conc = s_tdata[CONC_W-1:0];
  assign in_coef = s_tdata[CONC_W+COEF_W-1:CONC_W];
  assign in_ext  = s_tdata[CONC_W+COEF_W+EXT_W-1:CONC_W+COEF_W];

  // Clamp negative concentrations to zero and saturate the coefficient magnitude.
  always_comb begin
    coef_mag = in_coef[COEF_W-1] ? COEF_W'(-in_coef) : COEF_W'(in_coef);
    if (32'(coef_mag) > COEF_MAX) begin
      div_sat = DIV_W'(COEF_MAX);
    end else begin
      div_sat = DIV_W'(coef_mag);
    end
    dividend = in_conc[CONC_W-1] ? '0 : in_conc[QUO_W-1:0];
  end

  // Held species transaction.
  logic [QUO_W-1:0]        quo;
  logic [DIV_W-1:0]        rem;
  logic [DIV_W-1:0]        divisor;
  logic signed [EXT_W-1:0] extent;
  logic                    last_flag;
  logic                    coef_neg;
  logic                    coef_nz;
  logic [CNT_W-1:0]        cnt;

  // One restoring step: shift in the next dividend bit and try a subtract.
  logic [DIV_W:0] rem_sh;
  logic [DIV_W:0] diff;

  assign rem_sh = {rem, quo[QUO_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo       <= dividend;
      rem       <= '0;
      divisor   <= div_sat;
      extent    <= in_ext;
      last_flag <= s_tlast;
      coef_neg  <= in_coef[COEF_W-1];
      coef_nz   <= (in_coef != '0);
      cnt       <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
      if (!diff[DIV_W]) begin
        rem <= diff[DIV_W-1:0];
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIV_W-1:0];
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  // Running minima over reactants (forward) and products (reverse).
  logic               fwd_seen;
  logic               rev_seen;
  logic [LIMIT_W-1:0] fwd_min;
  logic [LIMIT_W-1:0] rev_min;

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      fwd_seen <= 1'b0;
      rev_seen <= 1'b0;
      fwd_min  <= '0;
      rev_min  <= '0;
    end else if (cmd.update && coef_nz) begin
      if (coef_neg) begin
        if (!fwd_seen || quo < fwd_min) begin
          fwd_min <= quo;
        end
        fwd_seen <= 1'b1;
      end else begin
        if (!rev_seen || quo < rev_min) begin
          rev_min <= quo;
        end
        rev_seen <= 1'b1;
      end
    end
  end

  // Blocked flag and clipping of the proposed extent.
  logic                    blocked;
  logic [EXT_W-1:0]        ext_neg_mag;
  logic signed [EXT_W-1:0] clipped;

  always_comb begin
    blocked     = fwd_seen && rev_seen && (fwd_min == '0) && (rev_min == '0);
    ext_neg_mag = EXT_W'(-extent);
    clipped     = extent;
    if (fwd_seen && !extent[EXT_W-1] && (extent != '0) &&
        (extent[LIMIT_W-1:0] > fwd_min)) begin
      clipped = signed'({1'b0, fwd_min});
    end else if (rev_seen && extent[EXT_W-1] &&
                 (ext_neg_mag > {1'b0, rev_min})) begin
      clipped = -signed'({1'b0, rev_min});
    end
    if (blocked) begin
      clipped = '0;
    end
  end

  // Result register: a finished result waits here while new species come in.
  logic                    res_fwd;
  logic                    res_rev;
  logic [LIMIT_W-1:0]      res_fwd_lim;
  logic [LIMIT_W-1:0]      res_rev_lim;
  logic                    res_blk;
  logic signed [EXT_W-1:0] res_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_fwd     <= fwd_seen;
      res_rev     <= rev_seen;
      res_fwd_lim <= fwd_min;
      res_rev_lim <= rev_min;
      res_blk     <= blocked;
      res_ext     <= clipped;
    end
  end

  assign m_tdata = {(OUT_DATA_W - OUT_RAW_W)'(0), res_ext, res_blk, res_rev_lim,
                    res_fwd_lim, res_rev, res_fwd};

  // Status back to the controller.
  assign status.div_done = (cnt == CNT_W'(QUO_W - 1));
  assign status.is_last  = last_flag;
  assign status.out_free = !m_tvalid || m_tready;

endmodule

### rtl/reaction_extent_limiter.sv
// ----------------------------------------------------------------------------
// Reaction extent limiter
// Folds a run of species into forward and reverse extent limits and, on the
// last species, reports the limits and the clipped proposed extent.
// ----------------------------------------------------------------------------
// Each species passes through one capture, 31 steps of the restoring divider
// and one minimum update before the next species is accepted.
// The last species of a reaction then loads the result, which waits in a
// result register; the load is held off while that register is still full.
// Reset (rst, synchronous) clears the minima, the controller and the output valid.
module reaction_extent_limiter
  import rel_pkg::*;
#(
  parameter int COEF_MAX = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  // Species transactions.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [31:0] concentration, [36:32] coefficient, [68:37] proposed_extent
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  // Result transactions.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] has_forward, [1] has_reverse, [32:2] forward_limit,
  // [63:33] reverse_limit, [64] blocked, [96:65] clipped_extent
  output logic [OUT_DATA_W-1:0] m_tdata
);

  rel_cmd_t    cmd;
  rel_status_t status;

  // Sequencing of one species at a time.
  rel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Divider, minima, clipping and result register.
  rel_dpath #(
    .COEF_MAX (COEF_MAX)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .status   (status)
  );

endmodule
